FILE: hw/rtl/ultrasonic_echo_ranger_macros.svh
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_ECHO_RANGER_MACROS_SVH
`define ULTRASONIC_ECHO_RANGER_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define UER_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define UER_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

FILE: hw/rtl/uer_pkg.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger package
// Widths, phase and status codes, and the types shared between modules.
// ----------------------------------------------------------------------------
package uer_pkg;

    localparam int COUNT_BITS = 16;
    localparam int MS_BITS    = 10;

    localparam int PERIOD_W   = 10;
    localparam int TIMEOUT_W  = 10;
    localparam int TRIGGER_W  = 4;
    localparam int SCALE_W    = 24;
    localparam int DIST_W     = 24;
    localparam int CFG_DATA_W = 24;
    localparam int CFG_IDX_W  = 2;

    // Compare width for elapsed time against the ms registers
    localparam int CMP_W = (MS_BITS > PERIOD_W) ? MS_BITS : PERIOD_W;

    // Width of the product, the rounded product and the shifted result
    localparam int PROD_W = COUNT_BITS + SCALE_W;
    localparam int RND_W  = PROD_W + 1;
    localparam int SHF_W  = ((RND_W - 16) > (DIST_W + 1)) ? (RND_W - 16) : (DIST_W + 1);

    localparam logic [MS_BITS-1:0]    MS_MAX    = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TRIGGER = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE   = 2'd3;

    // Register reset values
    localparam logic [PERIOD_W-1:0]  PERIOD_RST  = 10'd100;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 10'd100;
    localparam logic [TRIGGER_W-1:0] TRIGGER_RST = 4'd1;
    localparam logic [SCALE_W-1:0]   SCALE_RST   = 24'd285212;

    // Status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_ECHO  = 2'd1;
    localparam logic [1:0] ST_TOO_LONG = 2'd2;

    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_TRIG  = 4'b0010,
        PH_WAIT  = 4'b0100,
        PH_COUNT = 4'b1000
    } phase_t;

    typedef struct packed {
        logic [PERIOD_W-1:0]  period_ms;
        logic [TIMEOUT_W-1:0] timeout_ms;
        logic [TRIGGER_W-1:0] trigger_ms;
        logic [SCALE_W-1:0]   distance_scale;
    } cfg_t;

    typedef struct packed {
        logic                  trigger_level;
        logic                  done_res;
        logic [1:0]            status;
        logic [DIST_W-1:0]     distance_q8;
        logic [COUNT_BITS-1:0] echo_ticks;
    } res_t;

endpackage

FILE: hw/rtl/uer_cfg.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger configuration registers
// Holds the four setup registers, written through a plain write port.
// ----------------------------------------------------------------------------
module uer_cfg (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [uer_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output uer_pkg::cfg_t                    cfg
);

    uer_pkg::cfg_t cfg_reg;
    uer_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                uer_pkg::REG_PERIOD:
                    cfg_next.period_ms = cfg_wdata[uer_pkg::PERIOD_W-1:0];
                uer_pkg::REG_TIMEOUT:
                    cfg_next.timeout_ms = cfg_wdata[uer_pkg::TIMEOUT_W-1:0];
                uer_pkg::REG_TRIGGER:
                    cfg_next.trigger_ms = cfg_wdata[uer_pkg::TRIGGER_W-1:0];
                uer_pkg::REG_SCALE:
                    cfg_next.distance_scale = cfg_wdata[uer_pkg::SCALE_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.period_ms      <= uer_pkg::PERIOD_RST;
            cfg_reg.timeout_ms     <= uer_pkg::TIMEOUT_RST;
            cfg_reg.trigger_ms     <= uer_pkg::TRIGGER_RST;
            cfg_reg.distance_scale <= uer_pkg::SCALE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/uer_scale.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger distance scaler
// Multiplies the echo count by the Q0.24 scale, rounds to Q16.8, saturates.
// ----------------------------------------------------------------------------
module uer_scale (
    input  logic [uer_pkg::COUNT_BITS-1:0] count,
    input  logic [uer_pkg::SCALE_W-1:0]    scale,
    output logic [uer_pkg::DIST_W-1:0]     dist_q8
);

    logic [uer_pkg::PROD_W-1:0] prod;
    logic [uer_pkg::RND_W-1:0]  rnd;
    logic [uer_pkg::SHF_W-1:0]  shf;

    always_comb
    begin
        prod = uer_pkg::PROD_W'(count) * uer_pkg::PROD_W'(scale);
        // add half an LSB of the Q8 result, then drop 16 fraction bits
        rnd  = uer_pkg::RND_W'(prod) + uer_pkg::RND_W'(1 << 15);
        shf  = uer_pkg::SHF_W'(rnd >> 16);
        if (|shf[uer_pkg::SHF_W-1:uer_pkg::DIST_W])
            dist_q8 = '1;
        else
            dist_q8 = shf[uer_pkg::DIST_W-1:0];
    end

endmodule

FILE: hw/rtl/uer_core.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger measurement core
// Phase, elapsed-ms and echo-count state; one tick resolved per accept.
// ----------------------------------------------------------------------------
`include "ultrasonic_echo_ranger_macros.svh"

module uer_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic          echo_level,
    input  logic          ms_strobe,
    input  uer_pkg::cfg_t cfg,
    output uer_pkg::res_t res
);

    uer_pkg::phase_t                phase_reg;
    uer_pkg::phase_t                phase_next;
    logic [uer_pkg::MS_BITS-1:0]    elapsed_reg;
    logic [uer_pkg::MS_BITS-1:0]    elapsed_next;
    logic [uer_pkg::COUNT_BITS-1:0] count_reg;
    logic [uer_pkg::COUNT_BITS-1:0] count_next;

    logic [uer_pkg::MS_BITS-1:0]    el_inc;
    logic [uer_pkg::CMP_W-1:0]      el_cmp;
    logic                           timed_out;
    logic                           done;
    logic [1:0]                     status;
    logic                           dist_sel;
    logic [uer_pkg::DIST_W-1:0]     dist_q8;

    // distance always comes from the count held before this tick
    uer_scale u_scale (
        .count   (count_reg),
        .scale   (cfg.distance_scale),
        .dist_q8 (dist_q8)
    );

    always_comb
    begin
        el_inc = elapsed_reg;
        if (ms_strobe && (elapsed_reg != uer_pkg::MS_MAX))
            el_inc = elapsed_reg + 1'b1;
        el_cmp    = uer_pkg::CMP_W'(el_inc);
        timed_out = (el_cmp > uer_pkg::CMP_W'(cfg.timeout_ms))
                    || (el_inc == uer_pkg::MS_MAX);

        phase_next   = phase_reg;
        elapsed_next = el_inc;
        count_next   = count_reg;
        done         = 1'b0;
        status       = uer_pkg::ST_OK;
        dist_sel     = 1'b0;

        case (phase_reg)
            uer_pkg::PH_IDLE:
            begin
                if (el_cmp >= uer_pkg::CMP_W'(cfg.period_ms))
                begin
                    phase_next   = uer_pkg::PH_TRIG;
                    elapsed_next = '0;
                    count_next   = '0;
                end
            end
            uer_pkg::PH_TRIG:
            begin
                if (el_cmp >= uer_pkg::CMP_W'(cfg.trigger_ms))
                    phase_next = uer_pkg::PH_WAIT;
            end
            uer_pkg::PH_WAIT:
            begin
                if (echo_level)
                begin
                    phase_next = uer_pkg::PH_COUNT;
                    count_next = '0;
                end
                else if (timed_out)
                begin
                    done         = 1'b1;
                    status       = uer_pkg::ST_NO_ECHO;
                    phase_next   = uer_pkg::PH_IDLE;
                    elapsed_next = '0;
                end
            end
            uer_pkg::PH_COUNT:
            begin
                if (echo_level)
                begin
                    if (count_reg != uer_pkg::COUNT_MAX)
                        count_next = count_reg + 1'b1;
                    if (timed_out)
                    begin
                        done         = 1'b1;
                        status       = uer_pkg::ST_TOO_LONG;
                        phase_next   = uer_pkg::PH_IDLE;
                        elapsed_next = '0;
                    end
                end
                else
                begin
                    done       = 1'b1;
                    dist_sel   = 1'b1;
                    phase_next = uer_pkg::PH_IDLE;
                end
            end
            default:
            begin
                phase_next = uer_pkg::PH_IDLE;
            end
        endcase

        res.trigger_level = (phase_next == uer_pkg::PH_TRIG);
        res.done_res      = done;
        res.status        = status;
        res.distance_q8   = dist_sel ? dist_q8 : '0;
        res.echo_ticks    = count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= uer_pkg::PH_IDLE;
            elapsed_reg <= '0;
            count_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            count_reg   <= count_next;
        end
    end

    `UER_ASSERT_SAME(a_idle_never_done, accept && (phase_reg == uer_pkg::PH_IDLE), !res.done_res)
    `UER_ASSERT_NEXT(a_fall_to_idle, accept && (phase_reg == uer_pkg::PH_COUNT) && !echo_level,
        phase_reg == uer_pkg::PH_IDLE)
    `UER_ASSERT_NEXT(a_start_clears, accept && (phase_reg == uer_pkg::PH_IDLE)
        && (phase_next == uer_pkg::PH_TRIG), (elapsed_reg == '0) && (count_reg == '0))

endmodule

FILE: hw/rtl/uer_obuf.sv
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger result register
// Holds one result until taken; reloads in the same cycle it is taken.
// ----------------------------------------------------------------------------
module uer_obuf (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          load,
    input  uer_pkg::res_t res_in,
    input  logic          out_ready,
    output logic          out_valid,
    output logic          free,
    output uer_pkg::res_t res_out
);

    logic          valid_reg;
    logic          valid_next;
    uer_pkg::res_t res_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_in;
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

FILE: hw/rtl/ultrasonic_echo_ranger.sv
// An accepted request's result is registered and shows at the output in the cycle after it is accepted.
// Throughput: one request per cycle while the output is not stalled; the core state updates at every accepted tick.
// A stalled output holds one result; a new request enters in the cycle it is taken.
// Reset (rst_n low, asynchronous): phase idle, elapsed ms and echo count zero,
// output empty, registers back to period 100, timeout 100, trigger 1, scale 285212.
// ----------------------------------------------------------------------------
// Ultrasonic echo ranger top level
// Times the echo pulse of an ultrasonic ranger per count-clock tick, drives
// the trigger, and reports distance in Q16.8 cm or a timeout status.
// ----------------------------------------------------------------------------
`include "ultrasonic_echo_ranger_macros.svh"

module ultrasonic_echo_ranger (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic [uer_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    // tick requests
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic                             echo_level,
    input  logic                             ms_strobe,
    // results
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic                             trigger_level,
    output logic                             done_res,
    output logic [1:0]                       status,
    output logic [uer_pkg::DIST_W-1:0]       distance_q8,
    output logic [uer_pkg::COUNT_BITS-1:0]   echo_ticks
);

    uer_pkg::cfg_t cfg;
    uer_pkg::res_t res_core;
    uer_pkg::res_t res_out;
    logic          accept;
    logic          obuf_free;

    // Take a request whenever the result register is empty or being drained.
    assign in_ready = obuf_free;
    assign accept   = in_valid && in_ready;

    // Setup registers; write them only while no request is in flight.
    uer_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    // Resolve the tick: advance the ms count, step the phase, count echo,
    // and scale the count to distance on the echo falling edge.
    uer_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .echo_level (echo_level),
        .ms_strobe  (ms_strobe),
        .cfg        (cfg),
        .res        (res_core)
    );

    // Hold the result until the consumer takes it.
    uer_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (accept),
        .res_in    (res_core),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .free      (obuf_free),
        .res_out   (res_out)
    );

    assign trigger_level = res_out.trigger_level;
    assign done_res      = res_out.done_res;
    assign status        = res_out.status;
    assign distance_q8   = res_out.distance_q8;
    assign echo_ticks    = res_out.echo_ticks;

    // Every accepted request leaves a result behind it.
    `UER_ASSERT_NEXT(a_accept_gives_result, accept, out_valid)
    // A blocked input means a result is waiting.
    `UER_ASSERT_SAME(a_stall_has_result, !in_ready, out_valid && !out_ready)
    // Distance only appears on a good finish.
    `UER_ASSERT_SAME(a_dist_only_ok, out_valid && (distance_q8 != '0),
        done_res && (status == uer_pkg::ST_OK))

endmodule
